@@ hw/rtl/tcpq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the three-class priority queue.
// No dependencies.
package tcpq_pkg;

  // request action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  // entry classes
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_LOW  = 2'd1;
  localparam logic [1:0] CLS_MED  = 2'd2;
  localparam logic [1:0] CLS_HIGH = 2'd3;

  localparam int unsigned CLASS_BITS = 2;

  // control from the sequencer to the free slot pool
  typedef struct packed {
    logic rd;    // prefetch the top of the returned-slot stack
    logic take;  // consume the offered slot
    logic give;  // return a slot
  } pool_ctl_t;

endpackage

@@ hw/rtl/three_class_priority_queue_top.sv @@
`timescale 1ns / 1ps
// Three-class strict priority queue, FIFO within class, kept as one linked order.
// Depends on tcpq_pkg, tcpq_ram and tcpq_free_pool.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  request  | start_i, busy_o           | action_i, entry_class_i, entry_payload_i
//  result   | result_strobe_o (1 cycle) | out_payload_o, out_class_o, done_ok_o,
//           |                           | was_empty_o, was_full_o, occupancy_o,
//           |                           | inserts_total_o
//
// A request is taken when start_i is high and busy_o low; its result strobes in the cycle
// after the last work cycle. Insert behind an existing section: busy in ST_INS_A
// (read-modify of the predecessor link), then ST_INS_B (the new slot's link), both on
// the single link RAM port. Head insert: ST_INS_A only. Pop: ST_POP only. Rejected: none.
// Reset is asynchronous, active low; the queue comes up empty with no clearing pass.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module three_class_priority_queue_top import tcpq_pkg::*; #(
  parameter int unsigned SLOTS        = 64,
  parameter int unsigned PAYLOAD_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       action_i,
  input  logic [1:0]                 entry_class_i,
  input  logic [PAYLOAD_BITS-1:0]    entry_payload_i,
  output logic                       result_strobe_o,
  output logic [PAYLOAD_BITS-1:0]    out_payload_o,
  output logic [1:0]                 out_class_o,
  output logic                       done_ok_o,
  output logic                       was_empty_o,
  output logic                       was_full_o,
  output logic [$clog2(SLOTS+1)-1:0] occupancy_o,
  output logic [31:0]                inserts_total_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned DW = CLASS_BITS + PAYLOAD_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_INS_A, ST_INS_B, ST_POP} state_e;

  state_e                  state_q, state_d;
  logic [1:0]              class_q, class_d;
  logic [PAYLOAD_BITS-1:0] payload_q, payload_d;
  logic [IW-1:0]           slot_q, slot_d;
  logic [IW-1:0]           head_q, head_d;
  logic [IW-1:0]           tail_q [3];
  logic [IW-1:0]           tail_d [3];
  logic [2:0]              valid_q, valid_d;
  logic [CW-1:0]           held_q, held_d;
  logic [31:0]             tally_q, tally_d;

  logic                    res_strobe_q, res_strobe_d;
  logic [PAYLOAD_BITS-1:0] res_payload_q, res_payload_d;
  logic [1:0]              res_class_q, res_class_d;
  logic                    res_ok_q, res_ok_d;
  logic                    res_empty_q, res_empty_d;
  logic                    res_full_q, res_full_d;

  logic                    dram_en, dram_we;
  logic [IW-1:0]           dram_addr;
  logic [DW-1:0]           dram_wdata, dram_rdata;
  logic                    lram_en, lram_we;
  logic [IW-1:0]           lram_addr, lram_wdata, lram_rdata;

  pool_ctl_t               pool_ctl;
  logic [IW-1:0]           pool_slot;

  logic [1:0]              cls_in;
  logic [1:0]              cls_idx;
  logic                    found;
  logic [IW-1:0]           pred;
  logic [1:0]              pop_cls;
  logic [1:0]              pop_idx;

  // class zero is stored as low
  assign cls_in  = (entry_class_i == CLS_NONE) ? CLS_LOW : entry_class_i;
  assign cls_idx = class_q - 2'd1;
  assign pop_cls = (dram_rdata[PAYLOAD_BITS +: CLASS_BITS] == CLS_NONE) ? CLS_LOW
                   : dram_rdata[PAYLOAD_BITS +: CLASS_BITS];
  assign pop_idx = pop_cls - 2'd1;

  // predecessor: tail of the nearest non-empty section at or above the new entry's class
  always_comb begin
    case (class_q)
      CLS_HIGH: begin
        found = valid_q[2];
        pred  = tail_q[2];
      end
      CLS_MED: begin
        found = valid_q[1] | valid_q[2];
        pred  = valid_q[1] ? tail_q[1] : tail_q[2];
      end
      default: begin
        found = |valid_q;
        pred  = valid_q[0] ? tail_q[0] : (valid_q[1] ? tail_q[1] : tail_q[2]);
      end
    endcase
  end

  always_comb begin
    state_d       = state_q;
    class_d       = class_q;
    payload_d     = payload_q;
    slot_d        = slot_q;
    head_d        = head_q;
    tail_d        = tail_q;
    valid_d       = valid_q;
    held_d        = held_q;
    tally_d       = tally_q;
    res_strobe_d  = 1'b0;
    res_payload_d = res_payload_q;
    res_class_d   = res_class_q;
    res_ok_d      = res_ok_q;
    res_empty_d   = res_empty_q;
    res_full_d    = res_full_q;
    dram_en       = 1'b0;
    dram_we       = 1'b0;
    dram_addr     = head_q;
    dram_wdata    = {class_q, payload_q};
    lram_en       = 1'b0;
    lram_we       = 1'b0;
    lram_addr     = head_q;
    lram_wdata    = head_q;
    pool_ctl      = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (action_i == ACT_INSERT) begin
            if (held_q == CW'(SLOTS)) begin
              // drop: store full
              res_strobe_d  = 1'b1;
              res_payload_d = '0;
              res_class_d   = CLS_NONE;
              res_ok_d      = 1'b0;
              res_empty_d   = 1'b0;
              res_full_d    = 1'b1;
            end else begin
              pool_ctl.rd = 1'b1;
              class_d     = cls_in;
              payload_d   = entry_payload_i;
              state_d     = ST_INS_A;
            end
          end else begin
            if (held_q == '0) begin
              res_strobe_d  = 1'b1;
              res_payload_d = '0;
              res_class_d   = CLS_NONE;
              res_ok_d      = 1'b0;
              res_empty_d   = 1'b1;
              res_full_d    = 1'b0;
            end else begin
              dram_en = 1'b1;
              lram_en = 1'b1;
              state_d = ST_POP;
            end
          end
        end
      end

      ST_INS_A: begin
        pool_ctl.take    = 1'b1;
        slot_d           = pool_slot;
        dram_en          = 1'b1;
        dram_we          = 1'b1;
        dram_addr        = pool_slot;
        lram_en          = 1'b1;
        lram_we          = 1'b1;
        tail_d[cls_idx]  = pool_slot;
        valid_d[cls_idx] = 1'b1;
        held_d           = held_q + CW'(1);
        tally_d          = tally_q + 32'd1;
        if (found) begin
          // splice after pred, fetching its old successor in the same access
          lram_addr  = pred;
          lram_wdata = pool_slot;
          state_d    = ST_INS_B;
        end else begin
          lram_addr  = pool_slot;
          lram_wdata = head_q;
          head_d     = pool_slot;
          state_d    = ST_IDLE;
        end
        if (!found) begin
          res_strobe_d  = 1'b1;
          res_payload_d = '0;
          res_class_d   = CLS_NONE;
          res_ok_d      = 1'b1;
          res_empty_d   = 1'b0;
          res_full_d    = 1'b0;
        end
      end

      ST_INS_B: begin
        lram_en       = 1'b1;
        lram_we       = 1'b1;
        lram_addr     = slot_q;
        lram_wdata    = lram_rdata;
        state_d       = ST_IDLE;
        res_strobe_d  = 1'b1;
        res_payload_d = '0;
        res_class_d   = CLS_NONE;
        res_ok_d      = 1'b1;
        res_empty_d   = 1'b0;
        res_full_d    = 1'b0;
      end

      ST_POP: begin
        head_d        = lram_rdata;
        pool_ctl.give = 1'b1;
        held_d        = held_q - CW'(1);
        if (valid_q[pop_idx] && (tail_q[pop_idx] == head_q)) begin
          valid_d[pop_idx] = 1'b0;
        end
        if (held_q == CW'(1)) begin
          valid_d = '0;
        end
        state_d       = ST_IDLE;
        res_strobe_d  = 1'b1;
        res_payload_d = dram_rdata[PAYLOAD_BITS-1:0];
        res_class_d   = pop_cls;
        res_ok_d      = 1'b1;
        res_empty_d   = 1'b0;
        res_full_d    = 1'b0;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      class_q       <= CLS_LOW;
      payload_q     <= '0;
      slot_q        <= '0;
      head_q        <= '0;
      tail_q        <= '{default: '0};
      valid_q       <= '0;
      held_q        <= '0;
      tally_q       <= '0;
      res_strobe_q  <= 1'b0;
      res_payload_q <= '0;
      res_class_q   <= CLS_NONE;
      res_ok_q      <= 1'b0;
      res_empty_q   <= 1'b0;
      res_full_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      class_q       <= class_d;
      payload_q     <= payload_d;
      slot_q        <= slot_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      valid_q       <= valid_d;
      held_q        <= held_d;
      tally_q       <= tally_d;
      res_strobe_q  <= res_strobe_d;
      res_payload_q <= res_payload_d;
      res_class_q   <= res_class_d;
      res_ok_q      <= res_ok_d;
      res_empty_q   <= res_empty_d;
      res_full_q    <= res_full_d;
    end
  end

  tcpq_ram #(
    .Width (DW),
    .Depth (SLOTS)
  ) u_data_ram (
    .clk_i   (clk_i),
    .en_i    (dram_en),
    .we_i    (dram_we),
    .addr_i  (dram_addr),
    .wdata_i (dram_wdata),
    .rdata_o (dram_rdata)
  );

  tcpq_ram #(
    .Width (IW),
    .Depth (SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .en_i    (lram_en),
    .we_i    (lram_we),
    .addr_i  (lram_addr),
    .wdata_i (lram_wdata),
    .rdata_o (lram_rdata)
  );

  tcpq_free_pool #(
    .Slots (SLOTS)
  ) u_pool (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (pool_ctl),
    .give_slot_i (head_q),
    .slot_o      (pool_slot)
  );

  assign busy_o          = (state_q != ST_IDLE);
  assign result_strobe_o = res_strobe_q;
  assign out_payload_o   = res_payload_q;
  assign out_class_o     = res_class_q;
  assign done_ok_o       = res_ok_q;
  assign was_empty_o     = res_empty_q;
  assign was_full_o      = res_full_q;
  assign occupancy_o     = held_q;
  assign inserts_total_o = tally_q;

`ifndef NO_ASSERTIONS
  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_q |-> $onehot({res_ok_q, res_empty_q, res_full_q}))
    else $error("result carries more or less than one outcome");

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(SLOTS))
    else $error("occupancy above slot count");

  a_empty_sections: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == '0) |-> (valid_q == '0))
    else $error("section marked non-empty in empty queue");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_q |-> (state_q == ST_IDLE))
    else $error("result strobe while work is still in progress");

  a_insert_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (action_i == ACT_INSERT) && (held_q != CW'(SLOTS)))
      |=> (busy_o && !res_strobe_q))
    else $error("accepted insert did not start work");
`endif

endmodule

@@ hw/rtl/tcpq_ram.sv @@
`timescale 1ns / 1ps
// Single-port synchronous RAM, read-first, with registered read data.
// No dependencies.
module tcpq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read returns the old word when the same address is written
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem_q[addr_i];
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/tcpq_free_pool.sv @@
`timescale 1ns / 1ps
// Free slot pool: hands out never-used slots by counter, then returned slots from a stack.
// Depends on tcpq_pkg and tcpq_ram.
module tcpq_free_pool import tcpq_pkg::*; #(
  parameter int unsigned Slots = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pool_ctl_t                ctl_i,
  input  logic [$clog2(Slots)-1:0] give_slot_i,
  output logic [$clog2(Slots)-1:0] slot_o
);

  localparam int unsigned IW = $clog2(Slots);
  localparam int unsigned CW = $clog2(Slots + 1);

  logic [CW-1:0] fresh_q, fresh_d;
  logic [CW-1:0] stk_cnt_q, stk_cnt_d;
  logic [CW-1:0] stk_dec;
  logic          fresh_left;
  logic          stk_en;
  logic [IW-1:0] stk_addr;
  logic [IW-1:0] stk_rdata;

  assign fresh_left = (fresh_q != CW'(Slots));
  assign stk_dec    = stk_cnt_q - CW'(1);
  assign stk_en     = ctl_i.rd | ctl_i.give;
  assign stk_addr   = ctl_i.give ? stk_cnt_q[IW-1:0] : stk_dec[IW-1:0];
  assign slot_o     = fresh_left ? fresh_q[IW-1:0] : stk_rdata;

  always_comb begin
    fresh_d   = fresh_q;
    stk_cnt_d = stk_cnt_q;
    if (ctl_i.take) begin
      if (fresh_left) begin
        fresh_d = fresh_q + CW'(1);
      end else begin
        stk_cnt_d = stk_dec;
      end
    end
    if (ctl_i.give) begin
      stk_cnt_d = stk_cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q   <= '0;
      stk_cnt_q <= '0;
    end else begin
      fresh_q   <= fresh_d;
      stk_cnt_q <= stk_cnt_d;
    end
  end

  tcpq_ram #(
    .Width (IW),
    .Depth (Slots)
  ) u_stack (
    .clk_i   (clk_i),
    .en_i    (stk_en),
    .we_i    (ctl_i.give),
    .addr_i  (stk_addr),
    .wdata_i (give_slot_i),
    .rdata_o (stk_rdata)
  );

endmodule

@@ tb/tcpq_result_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the three-class priority queue: tracks held entries per class,
// predicts each result at request time and compares it field by field. Depends on tcpq_pkg.
module tcpq_result_checker import tcpq_pkg::*; #(
  parameter int unsigned SLOTS        = 64,
  parameter int unsigned PAYLOAD_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic                       action_i,
  input  logic [1:0]                 entry_class_i,
  input  logic [PAYLOAD_BITS-1:0]    entry_payload_i,
  input  logic                       result_strobe_i,
  input  logic [PAYLOAD_BITS-1:0]    out_payload_i,
  input  logic [1:0]                 out_class_i,
  input  logic                       done_ok_i,
  input  logic                       was_empty_i,
  input  logic                       was_full_i,
  input  logic [$clog2(SLOTS+1)-1:0] occupancy_i,
  input  logic [31:0]                inserts_total_i,
  output int unsigned                err_count_o,
  output int unsigned                pending_o,
  output int unsigned                popped_o,
  output int unsigned                empty_hits_o,
  output int unsigned                full_hits_o
);

  localparam int unsigned OW = $clog2(SLOTS + 1);

  typedef struct {
    logic [PAYLOAD_BITS-1:0]    payload;
    logic [1:0]                 cls;
    logic                       ok;
    logic                       empty;
    logic                       full;
    logic [$clog2(SLOTS+1)-1:0] occupancy;
    logic [31:0]                tally;
  } outcome_t;

  // entries held per class, oldest first
  logic [PAYLOAD_BITS-1:0] high_q[$];
  logic [PAYLOAD_BITS-1:0] med_q[$];
  logic [PAYLOAD_BITS-1:0] low_q[$];
  logic [31:0]             insert_tally;
  outcome_t                awaited_q[$];
  outcome_t                want;
  int unsigned             errors;
  int unsigned             popped;
  int unsigned             empty_hits;
  int unsigned             full_hits;

  function automatic outcome_t compute_outcome(input logic act, input logic [1:0] cls,
                                               input logic [PAYLOAD_BITS-1:0] pl);
    outcome_t    o;
    logic [1:0]  eff;
    int unsigned held;
    o = '{default: '0};
    held = unsigned'(high_q.size() + med_q.size() + low_q.size());
    if (act == ACT_INSERT) begin
      // class zero counts as low
      eff = (cls == CLS_NONE) ? CLS_LOW : cls;
      if (held == SLOTS) begin
        o.full = 1'b1;
        full_hits++;
      end else begin
        case (eff)
          CLS_HIGH: high_q.push_back(pl);
          CLS_MED:  med_q.push_back(pl);
          default:  low_q.push_back(pl);
        endcase
        insert_tally++;
        held++;
        o.ok = 1'b1;
      end
    end else if (held == 0) begin
      o.empty = 1'b1;
      empty_hits++;
    end else begin
      if (high_q.size() != 0) begin
        o.payload = high_q.pop_front();
        o.cls = CLS_HIGH;
      end else if (med_q.size() != 0) begin
        o.payload = med_q.pop_front();
        o.cls = CLS_MED;
      end else begin
        o.payload = low_q.pop_front();
        o.cls = CLS_LOW;
      end
      held--;
      popped++;
      o.ok = 1'b1;
    end
    o.occupancy = OW'(held);
    o.tally = insert_tally;
    return o;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q.delete();
      med_q.delete();
      low_q.delete();
      awaited_q.delete();
      insert_tally = '0;
      errors = 0;
      popped = 0;
      empty_hits = 0;
      full_hits = 0;
    end else begin
      // record the request first so a same-edge result still pairs with the oldest one
      if (start_i && !busy_i) begin
        awaited_q.push_back(compute_outcome(action_i, entry_class_i, entry_payload_i));
      end
      if (result_strobe_i) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: result strobe with no request outstanding, expected none, actual %0h",
                   $time, out_payload_i);
          errors++;
        end else begin
          want = awaited_q.pop_front();
          check_field("out_payload", 64'(want.payload), 64'(out_payload_i));
          check_field("out_class", 64'(want.cls), 64'(out_class_i));
          check_field("done_ok", 64'(want.ok), 64'(done_ok_i));
          check_field("was_empty", 64'(want.empty), 64'(was_empty_i));
          check_field("was_full", 64'(want.full), 64'(was_full_i));
          check_field("occupancy", 64'(want.occupancy), 64'(occupancy_i));
          check_field("inserts_total", 64'(want.tally), 64'(inserts_total_i));
        end
      end
    end
    err_count_o  <= errors;
    pending_o    <= unsigned'(awaited_q.size());
    popped_o     <= popped;
    empty_hits_o <= empty_hits;
    full_hits_o  <= full_hits;
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the three-class priority queue: drives requests under several pacing
// phases and gives the verdict. Depends on tcpq_pkg, the queue RTL and tcpq_result_checker.
module tb;
  import tcpq_pkg::*;

  localparam int unsigned SLOTS          = 64;
  localparam int unsigned PAYLOAD_BITS   = 16;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SEGMENT_ITEMS  = 161;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic                       action_i;
  logic [1:0]                 entry_class_i;
  logic [PAYLOAD_BITS-1:0]    entry_payload_i;
  logic                       result_strobe_o;
  logic [PAYLOAD_BITS-1:0]    out_payload_o;
  logic [1:0]                 out_class_o;
  logic                       done_ok_o;
  logic                       was_empty_o;
  logic                       was_full_o;
  logic [$clog2(SLOTS+1)-1:0] occupancy_o;
  logic [31:0]                inserts_total_o;

  int unsigned err_count;
  int unsigned pending;
  int unsigned popped;
  int unsigned empty_hits;
  int unsigned full_hits;
  int unsigned requests_sent;

  three_class_priority_queue_top #(
    .SLOTS       (SLOTS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .entry_class_i  (entry_class_i),
    .entry_payload_i(entry_payload_i),
    .result_strobe_o(result_strobe_o),
    .out_payload_o  (out_payload_o),
    .out_class_o    (out_class_o),
    .done_ok_o      (done_ok_o),
    .was_empty_o    (was_empty_o),
    .was_full_o     (was_full_o),
    .occupancy_o    (occupancy_o),
    .inserts_total_o(inserts_total_o)
  );

  tcpq_result_checker #(
    .SLOTS       (SLOTS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .action_i       (action_i),
    .entry_class_i  (entry_class_i),
    .entry_payload_i(entry_payload_i),
    .result_strobe_i(result_strobe_o),
    .out_payload_i  (out_payload_o),
    .out_class_i    (out_class_o),
    .done_ok_i      (done_ok_o),
    .was_empty_i    (was_empty_o),
    .was_full_i     (was_full_o),
    .occupancy_i    (occupancy_o),
    .inserts_total_i(inserts_total_o),
    .err_count_o    (err_count),
    .pending_o      (pending),
    .popped_o       (popped),
    .empty_hits_o   (empty_hits),
    .full_hits_o    (full_hits)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // present one request and hold it until taken
  task automatic issue(input logic act, input logic [1:0] cls, input logic [PAYLOAD_BITS-1:0] pl);
    @(negedge clk_i);
    start_i = 1'b1;
    action_i = act;
    entry_class_i = cls;
    entry_payload_i = pl;
    do @(posedge clk_i); while (busy_o);
    requests_sent++;
  endtask

  task automatic hold_off(input int unsigned cycles);
    @(negedge clk_i);
    start_i = 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // drop start and hold until every outstanding request has reported
  task automatic drain_results();
    hold_off(1);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned idle_pct[3];
    int unsigned pop_pct[3];
    logic        act;
    logic [1:0]  cls;
    idle_pct = '{0, 71, 8};
    pop_pct = '{15, 85, 50};
    requests_sent = 0;
    start_i = 1'b0;
    action_i = ACT_INSERT;
    entry_class_i = CLS_LOW;
    entry_payload_i = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty pop, every class including zero, payload extremes, priority order
    issue(ACT_POP, CLS_NONE, 16'hFFFF);
    issue(ACT_INSERT, CLS_LOW, 16'h0000);
    issue(ACT_INSERT, CLS_MED, 16'hFFFF);
    issue(ACT_INSERT, CLS_HIGH, 16'h8001);
    issue(ACT_INSERT, CLS_NONE, 16'h7FFE);
    issue(ACT_INSERT, CLS_HIGH, 16'hFFFF);
    issue(ACT_INSERT, CLS_MED, 16'h5555);
    issue(ACT_INSERT, CLS_LOW, 16'hAAAA);
    repeat (7) issue(ACT_POP, CLS_LOW, 16'h0000);
    issue(ACT_POP, CLS_HIGH, 16'h1234);
    issue(ACT_INSERT, CLS_LOW, 16'h0001);
    issue(ACT_INSERT, CLS_HIGH, 16'hFFFE);
    issue(ACT_INSERT, CLS_MED, 16'h00FF);
    repeat (3) issue(ACT_POP, CLS_MED, 16'hFF00);
    drain_results();

    // random: fill-biased, drain-biased and balanced segments under each pacing
    for (int p = 0; p < 3; p++) begin
      for (int s = 0; s < 3; s++) begin
        for (int n = 0; n < SEGMENT_ITEMS; n++) begin
          act = ($urandom_range(99) < pop_pct[s]) ? ACT_POP : ACT_INSERT;
          cls = ($urandom_range(9) == 0) ? CLS_NONE : 2'($urandom_range(3, 1));
          issue(act, cls, PAYLOAD_BITS'($urandom));
          if ($urandom_range(99) < idle_pct[p]) begin
            hold_off($urandom_range(5, 1));
          end
        end
      end
      drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d requests across three pacing phases.", requests_sent);
    $display("Entries popped: %0d, pops on empty: %0d, inserts refused as full: %0d.",
             popped, empty_hits, full_hits);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // end the run if neither channel moves for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || result_strobe_o) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog expired after %0d quiet cycles at %0t", quiet, $time);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
